// ===== hdl/lrsc_pkg.sv =====
// Package for the log record stream checker: types, codes, reset values and the CRC step.
package lrsc_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int HDR_BYTES = 16;
    localparam int CFG_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [31:0] MAGIC_RESET = 32'h4450_5741;
    localparam logic [15:0] VERSION_RESET = 16'd1;
    localparam logic [23:0] MAX_PAYLOAD_RESET = 24'd8388608;
    localparam logic [15:0] LOW_TYPE_RESET = 16'd0;
    localparam logic [15:0] HIGH_TYPE_RESET = 16'd6;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MAGIC     = 3'd0,
        CFG_VERSION   = 3'd1,
        CFG_MAX_LEN   = 3'd2,
        CFG_LOW_TYPE  = 3'd3,
        CFG_HIGH_TYPE = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HDR_TRUNC = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_PAY_TRUNC = 3'd3,
        ST_MAGIC     = 3'd4,
        ST_VERSION   = 3'd5,
        ST_TYPE      = 3'd6,
        ST_CRC       = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_STOPPED = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_first;
        logic       stream_last;
    } t_in_item;

    typedef struct packed {
        logic        has_payload_byte;
        logic [7:0]  payload_out;
        logic [15:0] kind_of_record;
        logic        record_done;
        logic [2:0]  status;
        logic        stream_done;
    } t_out_item;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// ===== hdl/log_record_stream_checker.sv =====
// Top level of the log record stream checker: header capture, record checks, CRC and output register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One byte per cycle while the input is not stalled: each byte is checked in the cycle it is
// accepted, with the bytewise CRC-32 step and the header compares in that cycle, and its result
// lands in the output register at the same edge, so a result appears in the cycle after its byte.
// Synchronous active-low reset restores the register defaults and the header phase.
// The input stalls only while a result sits in the output register and the output stalls.
module log_record_stream_checker
    import lrsc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  t_in_item                   i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output t_out_item                  o_out_data,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]       i_cfg_data
);

    logic [31:0] r_magic;
    logic [15:0] r_version;
    logic [23:0] r_max_len;
    logic [15:0] r_low_type;
    logic [15:0] r_high_type;

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_count, n_count;
    logic [7:0]             r_hdr [HDR_BYTES];
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic [31:0]            r_crc, n_crc;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic        in_fire;
    logic        emit;
    t_phase      eff_phase;
    logic [3:0]  eff_count;
    logic [7:0]  b;
    logic [31:0] len32;
    logic [31:0] hdr_crc_full;
    logic [31:0] hdr_crc_pay;
    logic [15:0] hdr_type;
    logic        hdr_done;
    t_status     hdr_status;
    logic        len_zero;
    logic [31:0] crc_next;
    logic [LENGTH_BITS-1:0] left_next;
    logic        pay_end;
    t_status     pay_status;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign b         = i_in_data.stream_byte;
    assign eff_phase = i_in_data.stream_first ? PH_HEADER : r_phase;
    assign eff_count = i_in_data.stream_first ? 4'd0 : r_count;
    assign hdr_done  = (eff_count == 4'd15);

    assign hdr_type     = {r_hdr[7], r_hdr[6]};
    assign len32        = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};
    assign hdr_crc_full = {b, r_hdr[14], r_hdr[13], r_hdr[12]};
    assign hdr_crc_pay  = {r_hdr[15], r_hdr[14], r_hdr[13], r_hdr[12]};
    assign len_zero     = (len32 == 32'd0);

    assign crc_next   = crc_byte(r_crc, b);
    assign left_next  = r_left - LENGTH_BITS'(1);
    assign pay_end    = (left_next == '0);
    assign pay_status = (~crc_next == hdr_crc_pay) ? ST_OK : ST_CRC;

    always_comb begin
        if ((len32 > {8'd0, r_max_len}) || ((len32 >> LENGTH_BITS) != 32'd0)) begin
            hdr_status = ST_TOO_LARGE;
        end else if ({r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]} != r_magic) begin
            hdr_status = ST_MAGIC;
        end else if ({r_hdr[5], r_hdr[4]} != r_version) begin
            hdr_status = ST_VERSION;
        end else if (hdr_type < r_low_type || hdr_type > r_high_type) begin
            hdr_status = ST_TYPE;
        end else if (len_zero) begin
            hdr_status = (hdr_crc_full == 32'd0) ? ST_OK : ST_CRC;
        end else begin
            hdr_status = ST_OK;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (in_fire) begin
            case (eff_phase)
                PH_HEADER: begin
                    if (!hdr_done) begin
                        n_phase = i_in_data.stream_last ? PH_STOPPED : PH_HEADER;
                    end else if (hdr_status != ST_OK || i_in_data.stream_last) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_phase = len_zero ? PH_HEADER : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (pay_end) begin
                        n_phase = (pay_status != ST_OK || i_in_data.stream_last) ?
                                  PH_STOPPED : PH_HEADER;
                    end else if (i_in_data.stream_last) begin
                        n_phase = PH_STOPPED;
                    end
                end
                default: n_phase = eff_phase;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_count = r_count;
        n_left  = r_left;
        n_crc   = r_crc;
        emit    = 1'b0;
        n_out   = r_out;
        if (in_fire) begin
            n_count = eff_count;
            n_out   = '0;
            case (eff_phase)
                PH_HEADER: begin
                    n_count = eff_count + 4'd1;
                    n_crc   = CRC_INIT;
                    n_left  = len32[LENGTH_BITS-1:0];
                    if (!hdr_done) begin
                        if (i_in_data.stream_last) begin
                            emit              = 1'b1;
                            n_out.record_done = 1'b1;
                            n_out.status      = ST_HDR_TRUNC;
                            n_out.stream_done = 1'b1;
                        end
                    end else begin
                        n_out.kind_of_record = hdr_type;
                        n_out.record_done    = 1'b1;
                        if (hdr_status != ST_OK) begin
                            emit              = 1'b1;
                            n_out.status      = hdr_status;
                            n_out.stream_done = 1'b1;
                        end else if (len_zero) begin
                            emit              = 1'b1;
                            n_out.status      = ST_OK;
                            n_out.stream_done = i_in_data.stream_last;
                        end else if (i_in_data.stream_last) begin
                            emit              = 1'b1;
                            n_out.status      = ST_PAY_TRUNC;
                            n_out.stream_done = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    emit                   = 1'b1;
                    n_crc                  = crc_next;
                    n_left                 = left_next;
                    n_out.has_payload_byte = 1'b1;
                    n_out.payload_out      = b;
                    n_out.kind_of_record   = hdr_type;
                    if (pay_end) begin
                        n_crc             = CRC_INIT;
                        n_count           = 4'd0;
                        n_out.record_done = 1'b1;
                        n_out.status      = pay_status;
                        n_out.stream_done = (pay_status != ST_OK) || i_in_data.stream_last;
                    end else if (i_in_data.stream_last) begin
                        n_out.record_done = 1'b1;
                        n_out.status      = ST_PAY_TRUNC;
                        n_out.stream_done = 1'b1;
                    end
                end
                default: emit = 1'b0;
            endcase
        end
        n_out_valid = in_fire ? emit : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic     <= MAGIC_RESET;
            r_version   <= VERSION_RESET;
            r_max_len   <= MAX_PAYLOAD_RESET;
            r_low_type  <= LOW_TYPE_RESET;
            r_high_type <= HIGH_TYPE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAGIC:     r_magic     <= i_cfg_data;
                CFG_VERSION:   r_version   <= i_cfg_data[15:0];
                CFG_MAX_LEN:   r_max_len   <= i_cfg_data[23:0];
                CFG_LOW_TYPE:  r_low_type  <= i_cfg_data[15:0];
                CFG_HIGH_TYPE: r_high_type <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_count     <= 4'd0;
            r_left      <= '0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_left      <= n_left;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_fire && eff_phase == PH_HEADER) begin
            r_hdr[eff_count] <= b;
        end
    end

endmodule

// ===== hdl/lrsc_checker.sv =====
// Port-level assertions for the log record stream checker, bound to the top level.
module lrsc_checker
    import lrsc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

    a_status_only_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.record_done |-> o_out_data.status == ST_OK &&
        !o_out_data.stream_done && o_out_data.has_payload_byte)
        else $error("status or stream end without record end");

    a_error_ends_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.stream_done)
        else $error("error did not end the stream");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_payload_byte |-> o_out_data.payload_out == 8'd0)
        else $error("payload byte set without payload flag");

endmodule

bind log_record_stream_checker lrsc_checker u_lrsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/tb_log_record_stream_checker.sv =====
// Self-checking testbench for log_record_stream_checker: stimulus, predictor and scoreboard.
module tb_log_record_stream_checker;
    timeunit 1ns;
    timeprecision 1ps;
    import lrsc_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int RESET_CYCLES = 12;
    localparam int ITEM_TARGET = 1450;
    localparam logic [31:0] LEN_LIMIT = (32'd1 << LENGTH_BITS_DEF) - 32'd1;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    t_in_item                   i_in_data;
    logic                       o_out_valid;
    logic                       i_out_stall;
    t_out_item                  o_out_data;
    logic                       i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_WIDTH-1:0]       i_cfg_data;

    log_record_stream_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // register copies
    logic [31:0] cfg_magic;
    logic [15:0] cfg_version;
    logic [23:0] cfg_max_len;
    logic [15:0] cfg_low_type;
    logic [15:0] cfg_high_type;

    // record state
    t_phase      rec_phase;
    int          hdr_fill;
    logic [7:0]  hdr_bytes [HDR_BYTES];
    logic [31:0] bytes_left;
    logic [31:0] crc_acc;

    t_out_item   expected_results [$];
    int          bytes_sent;
    int          bytes_live;
    int          streams;
    int          results_seen;
    int          errors;
    int          status_seen [8];

    typedef struct {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] kind;
        logic [31:0] length;
        logic [31:0] crc_flip;
        int          cut;
        bit          close;
        int          tail;
        bit          typed;
        t_status     want_st;
        bit          want_sd;
    } t_case;

    localparam int N_CASES = 16;
    t_case dir_cases [N_CASES] = '{
        '{MAGIC_RESET, 16'd1, 16'd0, 32'd0, 32'd0, 1, 1'b1, 2, 1'b1, ST_HDR_TRUNC, 1'b1},
        '{32'd0, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 16, 1'b0, 0, 1'b1, ST_TOO_LARGE, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'd0, 32'd8388609, 32'd0, 16, 1'b0, 1, 1'b1, ST_TOO_LARGE, 1'b1},
        '{~MAGIC_RESET, 16'hFFFF, 16'd7, 32'd0, 32'd0, 0, 1'b0, 0, 1'b1, ST_MAGIC, 1'b1},
        '{MAGIC_RESET, 16'd0, 16'd9, 32'd0, 32'd0, 0, 1'b0, 0, 1'b1, ST_VERSION, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'd7, 32'd0, 32'd0, 0, 1'b0, 0, 1'b1, ST_TYPE, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'hFFFF, 32'd5, 32'd0, 16, 1'b0, 0, 1'b1, ST_TYPE, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'd0, 32'd0, 32'd0, 0, 1'b1, 2, 1'b1, ST_OK, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'd6, 32'd0, 32'd1, 0, 1'b0, 0, 1'b1, ST_CRC, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'd3, 32'd3, 32'd0, 16, 1'b1, 0, 1'b1, ST_PAY_TRUNC, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'd2, 32'd5, 32'd0, 18, 1'b1, 0, 1'b1, ST_PAY_TRUNC, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'd1, 32'd4, 32'h8000_0000, 0, 1'b0, 0, 1'b1, ST_CRC, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'd6, 32'd1, 32'd0, 0, 1'b1, 0, 1'b1, ST_OK, 1'b1},
        '{MAGIC_RESET, 16'd1, 16'd4, 32'd2, 32'd0, 0, 1'b0, 0, 1'b1, ST_OK, 1'b0},
        '{MAGIC_RESET, 16'd1, 16'd5, 32'd3, 32'd0, 7, 1'b0, 0, 1'b0, ST_OK, 1'b0},
        '{MAGIC_RESET, 16'd1, 16'd0, 32'd6, 32'd0, 0, 1'b1, 0, 1'b0, ST_OK, 1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] x;
        x = c;
        for (int k = 0; k < 8; k++) begin
            x = (x[0] ^ d[k]) ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic void clear_record();
        hdr_fill = 0;
        foreach (hdr_bytes[i]) hdr_bytes[i] = 8'd0;
        bytes_left = 32'd0;
        crc_acc = CRC_INIT;
    endfunction

    function automatic bit predict_step(input t_in_item it, output t_out_item r);
        logic [31:0] magic;
        logic [31:0] plen;
        logic [31:0] pcrc;
        logic [15:0] ver;
        logic [15:0] kind;
        t_status     st;
        r = '0;
        if (it.stream_first) begin
            rec_phase = PH_HEADER;
            clear_record();
        end
        if (rec_phase == PH_STOPPED) return 1'b0;
        bytes_live++;
        if (rec_phase == PH_HEADER) begin
            hdr_bytes[hdr_fill] = it.stream_byte;
            hdr_fill++;
            if (hdr_fill < HDR_BYTES) begin
                if (it.stream_last) begin
                    r.record_done = 1'b1;
                    r.status = ST_HDR_TRUNC;
                    r.stream_done = 1'b1;
                    rec_phase = PH_STOPPED;
                    return 1'b1;
                end
                return 1'b0;
            end
            hdr_fill = 0;
        end
        magic = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
        ver   = {hdr_bytes[5], hdr_bytes[4]};
        kind  = {hdr_bytes[7], hdr_bytes[6]};
        plen  = {hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8]};
        pcrc  = {hdr_bytes[15], hdr_bytes[14], hdr_bytes[13], hdr_bytes[12]};
        r.kind_of_record = kind;
        if (rec_phase == PH_HEADER) begin
            st = ST_OK;
            if (plen > {8'd0, cfg_max_len} || plen > LEN_LIMIT) st = ST_TOO_LARGE;
            else if (magic != cfg_magic) st = ST_MAGIC;
            else if (ver != cfg_version) st = ST_VERSION;
            else if (kind < cfg_low_type || kind > cfg_high_type) st = ST_TYPE;
            if (st != ST_OK) begin
                r.record_done = 1'b1;
                r.status = st;
                r.stream_done = 1'b1;
                rec_phase = PH_STOPPED;
                return 1'b1;
            end
            if (plen == 32'd0) begin
                r.record_done = 1'b1;
                r.status = (pcrc == 32'd0) ? ST_OK : ST_CRC;
                r.stream_done = (pcrc != 32'd0) || it.stream_last;
                rec_phase = r.stream_done ? PH_STOPPED : PH_HEADER;
                clear_record();
                return 1'b1;
            end
            bytes_left = plen;
            rec_phase = PH_PAYLOAD;
            if (it.stream_last) begin
                r.record_done = 1'b1;
                r.status = ST_PAY_TRUNC;
                r.stream_done = 1'b1;
                rec_phase = PH_STOPPED;
                return 1'b1;
            end
            return 1'b0;
        end
        crc_acc = crc32_next(crc_acc, it.stream_byte);
        bytes_left--;
        r.has_payload_byte = 1'b1;
        r.payload_out = it.stream_byte;
        if (bytes_left == 32'd0) begin
            r.record_done = 1'b1;
            r.status = (~crc_acc == pcrc) ? ST_OK : ST_CRC;
            r.stream_done = (~crc_acc != pcrc) || it.stream_last;
            rec_phase = r.stream_done ? PH_STOPPED : PH_HEADER;
            clear_record();
        end else if (it.stream_last) begin
            r.record_done = 1'b1;
            r.status = ST_PAY_TRUNC;
            r.stream_done = 1'b1;
            rec_phase = PH_STOPPED;
        end
        return 1'b1;
    endfunction

    function automatic void append_record(ref logic [7:0] seq [$], input logic [31:0] magic,
                                          input logic [15:0] ver, input logic [15:0] kind,
                                          input logic [31:0] plen, input int n_pay,
                                          input logic [31:0] crc_flip);
        logic [7:0]   pay [$];
        logic [31:0]  c;
        logic [127:0] h;
        c = CRC_INIT;
        for (int i = 0; i < n_pay; i++) begin
            pay = {pay, 8'($urandom)};
            c = crc32_next(c, pay[i]);
        end
        h = {~c ^ crc_flip, plen, kind, ver, magic};
        for (int i = 0; i < HDR_BYTES; i++) seq = {seq, h[8*i +: 8]};
        foreach (pay[i]) seq = {seq, pay[i]};
    endfunction

    task automatic push_byte(input t_in_item it, input bit typed, input t_status want_st,
                             input bit want_sd);
        int        gap;
        bit        has;
        t_out_item r;
        gap = ((bytes_sent / 80) % 4 == 0) ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        has = predict_step(it, r);
        if (typed) begin
            r.record_done = 1'b1;
            r.status = want_st;
            r.stream_done = want_sd;
            has = 1'b1;
        end
        if (has) expected_results = {expected_results, r};
    endtask

    task automatic send_bytes(input logic [7:0] seq [$], input bit close, input bit typed,
                              input t_status want_st, input bit want_sd);
        t_in_item it;
        streams++;
        foreach (seq[i]) begin
            it.stream_byte = seq[i];
            it.stream_first = (i == 0);
            it.stream_last = close && (i == seq.size() - 1);
            push_byte(it, typed && (i == seq.size() - 1), want_st, want_sd);
        end
    endtask

    task automatic send_noise(input int n, input bit open);
        t_in_item it;
        if (open) streams++;
        for (int i = 0; i < n; i++) begin
            it.stream_byte = 8'($urandom);
            it.stream_first = open && (i == 0 || $urandom_range(0, 15) == 0);
            it.stream_last = ($urandom_range(0, 7) == 0);
            push_byte(it, 1'b0, ST_OK, 1'b0);
        end
    endtask

    task automatic random_stream();
        logic [7:0]  seq [$];
        logic [31:0] magic;
        logic [31:0] plen;
        logic [31:0] flip;
        logic [15:0] ver;
        logic [15:0] kind;
        int          n_rec;
        int          flaw;
        int          cap;
        int          n_pay;
        bit          close;
        bit          broken;
        n_rec = $urandom_range(1, 4);
        close = ($urandom_range(0, 3) != 0);
        broken = 1'b0;
        flaw = 19;
        n_pay = 0;
        for (int k = 0; k < n_rec && !broken; k++) begin
            flaw = $urandom_range(0, 19);
            magic = cfg_magic;
            ver = cfg_version;
            flip = 32'd0;
            if (cfg_low_type <= cfg_high_type)
                kind = 16'($urandom_range(cfg_low_type, cfg_high_type));
            else
                kind = 16'($urandom);
            cap = (cfg_max_len < 24'd12) ? int'(cfg_max_len) : 12;
            if ($urandom_range(0, 15) == 0 && cfg_max_len >= 24'd40) cap = 40;
            plen = $urandom_range(0, cap);
            case (flaw)
                0: plen = $urandom_range(0, 1) ? ($urandom | 32'h0100_0000)
                                               : {8'd0, cfg_max_len} + $urandom_range(1, 3);
                1: magic = magic ^ (32'd1 << $urandom_range(0, 31));
                2: ver = ver ^ (16'd1 << $urandom_range(0, 15));
                3: begin
                    if (cfg_low_type > 16'd0 &&
                        (cfg_high_type == 16'hFFFF || $urandom_range(0, 1)))
                        kind = 16'($urandom_range(0, int'(cfg_low_type) - 1));
                    else if (cfg_high_type != 16'hFFFF)
                        kind = 16'($urandom_range(int'(cfg_high_type) + 1, 65535));
                end
                4: flip = 32'd1 << $urandom_range(0, 31);
                default: ;
            endcase
            n_pay = (flaw == 0) ? 0 : int'(plen);
            append_record(seq, magic, ver, kind, plen, n_pay, flip);
            broken = (flaw <= 5);
        end
        if (flaw == 5) begin
            repeat ($urandom_range(1, HDR_BYTES + n_pay - 1)) void'(seq.pop_back());
            close = 1'b1;
        end
        send_bytes(seq, close, 1'b0, ST_OK, 1'b0);
        if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 3), 1'b0);
    endtask

    task automatic run_random(input int target);
        while (bytes_sent < target) begin
            if ($urandom_range(0, 11) == 0) send_noise($urandom_range(1, 20), 1'b1);
            else random_stream();
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MAGIC:     cfg_magic = val;
            CFG_VERSION:   cfg_version = val[15:0];
            CFG_MAX_LEN:   cfg_max_len = val[23:0];
            CFG_LOW_TYPE:  cfg_low_type = val[15:0];
            CFG_HIGH_TYPE: cfg_high_type = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] magic, input logic [15:0] ver,
                              input logic [23:0] max_len, input logic [15:0] lo,
                              input logic [15:0] hi);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_VERSION, {16'd0, ver});
        write_reg(CFG_MAX_LEN, {8'd0, max_len});
        write_reg(CFG_LOW_TYPE, {16'd0, lo});
        write_reg(CFG_HIGH_TYPE, {16'd0, hi});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, o_out_data);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.has_payload_byte !== want.has_payload_byte ||
                    o_out_data.payload_out !== want.payload_out ||
                    o_out_data.kind_of_record !== want.kind_of_record ||
                    o_out_data.record_done !== want.record_done ||
                    o_out_data.status !== want.status ||
                    o_out_data.stream_done !== want.stream_done) begin
                    errors++;
                    $display("%0t: expected has=%0d byte=%h kind=%h done=%0d st=%0d end=%0d",
                             $time, want.has_payload_byte, want.payload_out,
                             want.kind_of_record, want.record_done, want.status,
                             want.stream_done);
                    $display("%0t:   actual has=%0d byte=%h kind=%h done=%0d st=%0d end=%0d",
                             $time, o_out_data.has_payload_byte, o_out_data.payload_out,
                             o_out_data.kind_of_record, o_out_data.record_done,
                             o_out_data.status, o_out_data.stream_done);
                end
            end
            results_seen++;
            if (o_out_data.record_done) status_seen[o_out_data.status]++;
        end
    end

    initial begin : out_drain
        int pause_left;
        int taken;
        bit held_long;
        pause_left = 0;
        taken = 0;
        held_long = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                taken++;
                if (!held_long && taken >= 150) begin
                    pause_left = LONG_HOLD_CYCLES;
                    held_long = 1'b1;
                end else if ((taken / 64) % 3 == 0) begin
                    pause_left = 0;
                end else begin
                    pause_left = $urandom_range(0, 6);
                end
            end
            @(negedge i_clk);
            if (pause_left > 0) begin
                i_out_stall <= 1'b1;
                pause_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("tb_log_record_stream_checker NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] seq [$];
        t_case      tc;
        logic [15:0] lo;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        bytes_sent = 0;
        bytes_live = 0;
        streams = 0;
        results_seen = 0;
        errors = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        cfg_magic = MAGIC_RESET;
        cfg_version = VERSION_RESET;
        cfg_max_len = MAX_PAYLOAD_RESET;
        cfg_low_type = LOW_TYPE_RESET;
        cfg_high_type = HIGH_TYPE_RESET;
        rec_phase = PH_HEADER;
        clear_record();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_cases[n]) begin
            tc = dir_cases[n];
            seq.delete();
            append_record(seq, tc.magic, tc.version, tc.kind, tc.length,
                          (tc.length <= 32'd64) ? int'(tc.length) : 0, tc.crc_flip);
            if (tc.cut > 0) begin
                while (seq.size() > tc.cut) void'(seq.pop_back());
            end
            send_bytes(seq, tc.close, tc.typed, tc.want_st, tc.want_sd);
            send_noise(tc.tail, 1'b0);
        end

        settle();
        set_config(32'hFFFF_FFFF, 16'hFFFF, MAX_PAYLOAD_RESET, 16'h0000, 16'hFFFF);
        run_random(300);
        settle();
        set_config(32'h0000_0000, 16'h0000, 24'd0, 16'h0000, 16'h0000);
        run_random(500);
        settle();
        lo = 16'($urandom_range(0, 65000));
        set_config($urandom, 16'($urandom), 24'($urandom_range(1, 24)), lo,
                   lo + 16'($urandom_range(0, 500)));
        run_random(800);
        settle();
        set_config(MAGIC_RESET, VERSION_RESET, 24'd30, 16'd5, 16'd2);
        run_random(920);
        settle();
        set_config($urandom, 16'($urandom), 24'($urandom_range(0, 8388608)),
                   16'($urandom), 16'($urandom));
        run_random(1150);
        settle();
        set_config(MAGIC_RESET, VERSION_RESET, MAX_PAYLOAD_RESET, LOW_TYPE_RESET,
                   HIGH_TYPE_RESET);
        run_random(ITEM_TARGET);
        settle();

        $display("Run: %0d streams, %0d bytes transferred (%0d live), %0d results checked",
                 streams, bytes_sent, bytes_live, results_seen);
        $display("Ends: ok %0d, hdr %0d, big %0d, cut %0d, magic %0d, ver %0d, type %0d, crc %0d",
                 status_seen[ST_OK], status_seen[ST_HDR_TRUNC], status_seen[ST_TOO_LARGE],
                 status_seen[ST_PAY_TRUNC], status_seen[ST_MAGIC], status_seen[ST_VERSION],
                 status_seen[ST_TYPE], status_seen[ST_CRC]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb_log_record_stream_checker OK");
        end else begin
            $display("tb_log_record_stream_checker NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lrsc_pkg.sv
hdl/log_record_stream_checker.sv
hdl/lrsc_checker.sv
tb/sv/tb_log_record_stream_checker.sv
